// File: rtl/frhb_pkg.sv
// Shared constants, register index codes and stage payload types of the height blend.
`default_nettype none

package frhb_pkg;

  localparam int ANGLE_FRAC_BITS  = 16;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int LON_W    = 25;
  localparam int LAT_W    = 24;
  localparam int SPAN_W   = 24;
  localparam int HEIGHT_W = 32;
  localparam int WEIGHT_W = 17;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LON_W;

  localparam int LON_DIFF_W = LON_W + 1;
  localparam int LAT_DIFF_W = LAT_W + 1;
  localparam int DIST_W     = SPAN_W;
  localparam int DELTA_W    = HEIGHT_W + 1;

  // smoothstep ratio and divider shape
  localparam int T_W        = WEIGHT_FRAC_BITS;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = T_W / DIV_STEP;

  localparam longint FULL_TURN = 64'(360) << ANGLE_FRAC_BITS;
  localparam longint HALF_TURN = 64'(180) << ANGLE_FRAC_BITS;
  localparam longint W_ONE     = 64'(1) << WEIGHT_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_LON = 3'd0,
    CFG_HALF_LON   = 3'd1,
    CFG_SOUTH_LAT  = 3'd2,
    CFG_NORTH_LAT  = 3'd3,
    CFG_FEATHER    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [LON_W-1:0] center_lon;
    logic [SPAN_W-1:0]       half_lon;
    logic signed [LAT_W-1:0] south;
    logic signed [LAT_W-1:0] north;
    logic [SPAN_W-1:0]       feather;
  } cfg_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] base;
    logic signed [DELTA_W-1:0]  delta;
  } hgt_t;

  typedef struct packed {
    hgt_t              hgt;
    logic              in_rect;
    logic              beyond;
    logic [DIST_W-1:0] rem;
  } dist_res_t;

  typedef struct packed {
    hgt_t           hgt;
    logic           in_rect;
    logic           beyond;
    logic [T_W-1:0] t;
  } ratio_t;

  typedef struct packed {
    hgt_t                hgt;
    logic [WEIGHT_W-1:0] weight;
  } wgt_t;

endpackage

`default_nettype wire

// File: rtl/frhb_in_if.sv
// Sample channel: valid/ready handshake with one terrain sample as payload.
`default_nettype none

interface frhb_in_if;
  import frhb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [LON_W-1:0]    sample_lon;
  logic signed [LAT_W-1:0]    sample_lat;
  logic signed [HEIGHT_W-1:0] base_height;
  logic signed [HEIGHT_W-1:0] filtered_height;

  modport source (output valid, sample_lon, sample_lat, base_height, filtered_height,
                  input ready);
  modport sink (input valid, sample_lon, sample_lat, base_height, filtered_height,
                output ready);
endinterface

`default_nettype wire

// File: rtl/frhb_out_if.sv
// Result channel: valid/ready handshake with blended height and weight as payload.
`default_nettype none

interface frhb_out_if;
  import frhb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] blended_height;
  logic [WEIGHT_W-1:0]        region_weight;

  modport source (output valid, blended_height, region_weight, input ready);
  modport sink (input valid, blended_height, region_weight, output ready);
endinterface

`default_nettype wire

// File: rtl/frhb_dist.sv
// Four-stage distance pipeline: wrapped lon offset, lat overshoot, edge distance, band test.
`default_nettype none

module frhb_dist (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire frhb_pkg::cfg_t                      cfg,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [frhb_pkg::LON_W-1:0]   sample_lon,
  input  wire logic signed [frhb_pkg::LAT_W-1:0]   sample_lat,
  input  wire logic signed [frhb_pkg::HEIGHT_W-1:0] base_height,
  input  wire logic signed [frhb_pkg::HEIGHT_W-1:0] filtered_height,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output frhb_pkg::dist_res_t                      out_data
);
  import frhb_pkg::*;

  localparam int NSTG = 4;
  localparam int DL_W = LON_DIFF_W + 1;
  localparam logic signed [LON_DIFF_W-1:0] HALF_S = LON_DIFF_W'(HALF_TURN);
  localparam logic signed [LON_DIFF_W-1:0] FULL_S = LON_DIFF_W'(FULL_TURN);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;

  logic signed [LON_DIFF_W-1:0] lon_d_r;
  logic signed [LAT_DIFF_W-1:0] lat_s_r;
  logic signed [LAT_DIFF_W-1:0] lat_n_r;
  hgt_t                         hgt0_r;

  logic signed [LON_DIFF_W-1:0] off_r;
  logic signed [LON_DIFF_W-1:0] off_nxt;
  logic [DIST_W-1:0]            dlat1_r;
  logic [DIST_W-1:0]            dlat_nxt;
  logic signed [LAT_DIFF_W-1:0] lat_m;
  hgt_t                         hgt1_r;

  logic signed [DL_W-1:0] off_x;
  logic signed [DL_W-1:0] half_x;
  logic signed [DL_W-1:0] dl;
  logic [DIST_W-1:0]      dlon_nxt;
  logic [DIST_W-1:0]      dlon2_r;
  logic [DIST_W-1:0]      dlat2_r;
  hgt_t                   hgt2_r;

  logic [DIST_W-1:0] d;
  dist_res_t         res_nxt;
  dist_res_t         res_r;

  // a stage takes new data when it is empty or its contents move on
  assign rdy[NSTG] = out_ready;
  for (genvar g = 0; g < NSTG; g++) begin : g_rdy
    assign rdy[g] = ~v_r[g] | rdy[g+1];
  end

  assign v_nxt = (rdy[NSTG-1:0] & {v_r[NSTG-2:0], in_valid}) | (~rdy[NSTG-1:0] & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 0: raw offsets and height difference
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lon_d_r      <= LON_DIFF_W'(sample_lon) - LON_DIFF_W'($signed(cfg.center_lon));
      lat_s_r      <= LAT_DIFF_W'($signed(cfg.south)) - LAT_DIFF_W'(sample_lat);
      lat_n_r      <= LAT_DIFF_W'(sample_lat) - LAT_DIFF_W'($signed(cfg.north));
      hgt0_r.base  <= base_height;
      hgt0_r.delta <= DELTA_W'(filtered_height) - DELTA_W'(base_height);
    end
  end

  // stage 1: fold lon offset into [-180,180), one turn is always enough
  always_comb begin
    off_nxt = lon_d_r;
    if (lon_d_r < -HALF_S) begin
      off_nxt = lon_d_r + FULL_S;
    end else if (lon_d_r >= HALF_S) begin
      off_nxt = lon_d_r - FULL_S;
    end
    lat_m    = (lat_s_r > lat_n_r) ? lat_s_r : lat_n_r;
    dlat_nxt = lat_m[LAT_DIFF_W-1] ? '0 : lat_m[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      off_r   <= off_nxt;
      dlat1_r <= dlat_nxt;
      hgt1_r  <= hgt0_r;
    end
  end

  // stage 2: |off| - half span, both signs formed side by side
  always_comb begin
    off_x    = DL_W'(off_r);
    half_x   = $signed({{(DL_W-SPAN_W){1'b0}}, cfg.half_lon});
    dl       = off_r[LON_DIFF_W-1] ? (-off_x - half_x) : (off_x - half_x);
    dlon_nxt = dl[DL_W-1] ? '0 : dl[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dlon2_r <= dlon_nxt;
      dlat2_r <= dlat1_r;
      hgt2_r  <= hgt1_r;
    end
  end

  // stage 3: distance and band classification
  always_comb begin
    d               = (dlon2_r > dlat2_r) ? dlon2_r : dlat2_r;
    res_nxt.hgt     = hgt2_r;
    res_nxt.in_rect = (d == '0);
    res_nxt.beyond  = (d >= cfg.feather);
    res_nxt.rem     = cfg.feather - d;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      res_r <= res_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = res_r;

endmodule

`default_nettype wire

// File: rtl/frhb_div.sv
// Pipelined restoring divider: t = floor(rem * 2^T_W / feather), DIV_STEP bits per stage.
`default_nettype none

module frhb_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [frhb_pkg::DIST_W-1:0]  feather,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire frhb_pkg::dist_res_t          in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output frhb_pkg::ratio_t                  out_data
);
  import frhb_pkg::*;

  localparam int NSTG = DIV_STAGES;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;

  logic [DIST_W-1:0] rem_r   [NSTG];
  ratio_t            dat_r   [NSTG];
  logic [DIST_W-1:0] rem_src [NSTG];
  ratio_t            dat_src [NSTG];
  logic [DIST_W-1:0] rem_nxt [NSTG];
  ratio_t            dat_nxt [NSTG];

  assign rdy[NSTG] = out_ready;
  for (genvar g = 0; g < NSTG; g++) begin : g_rdy
    assign rdy[g] = ~v_r[g] | rdy[g+1];
  end

  if (NSTG > 1) begin : g_vmany
    assign v_nxt = (rdy[NSTG-1:0] & {v_r[NSTG-2:0], in_valid}) | (~rdy[NSTG-1:0] & v_r);
  end else begin : g_vone
    assign v_nxt = (rdy[0] & in_valid) | (~rdy[0] & v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    rem_src[0]         = in_data.rem;
    dat_src[0].hgt     = in_data.hgt;
    dat_src[0].in_rect = in_data.in_rect;
    dat_src[0].beyond  = in_data.beyond;
    dat_src[0].t       = '0;
    for (int s = 1; s < NSTG; s++) begin
      rem_src[s] = rem_r[s-1];
      dat_src[s] = dat_r[s-1];
    end
  end

  // each stage shifts in DIV_STEP quotient bits
  always_comb begin
    logic [DIST_W:0] r2;
    logic [T_W-1:0]  q;
    logic [DIST_W-1:0] rem;
    r2 = '0;
    for (int s = 0; s < NSTG; s++) begin
      rem = rem_src[s];
      q   = dat_src[s].t;
      for (int k = 0; k < DIV_STEP; k++) begin
        r2 = {rem, 1'b0};
        if (r2 >= {1'b0, feather}) begin
          r2 = r2 - {1'b0, feather};
          q  = {q[T_W-2:0], 1'b1};
        end else begin
          q  = {q[T_W-2:0], 1'b0};
        end
        rem = r2[DIST_W-1:0];
      end
      rem_nxt[s]   = rem;
      dat_nxt[s]   = dat_src[s];
      dat_nxt[s].t = q;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (rdy[s]) begin
        rem_r[s] <= rem_nxt[s];
        dat_r[s] <= dat_nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = dat_r[NSTG-1];

endmodule

`default_nettype wire

// File: rtl/frhb_weight.sv
// Two-stage smoothstep: t*t and (3 - 2t), then their product scaled to the weight.
`default_nettype none

module frhb_weight (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire frhb_pkg::ratio_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output frhb_pkg::wgt_t         out_data
);
  import frhb_pkg::*;

  localparam int NSTG = 2;
  localparam int K_W  = WEIGHT_FRAC_BITS + 2;
  localparam int S_W  = 2 * T_W + K_W;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;

  logic [2*T_W-1:0] tt_r;
  logic [K_W-1:0]   k_r;
  hgt_t             hgt0_r;
  logic             inside0_r;
  logic             beyond0_r;

  logic [S_W-1:0]   s;
  wgt_t             res_nxt;
  wgt_t             res_r;

  assign rdy[NSTG] = out_ready;
  for (genvar g = 0; g < NSTG; g++) begin : g_rdy
    assign rdy[g] = ~v_r[g] | rdy[g+1];
  end

  assign v_nxt = (rdy[NSTG-1:0] & {v_r[NSTG-2:0], in_valid}) | (~rdy[NSTG-1:0] & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      tt_r      <= (2*T_W)'(in_data.t) * (2*T_W)'(in_data.t);
      k_r       <= K_W'(3 * W_ONE) - K_W'({in_data.t, 1'b0});
      hgt0_r    <= in_data.hgt;
      inside0_r <= in_data.in_rect;
      beyond0_r <= in_data.beyond;
    end
  end

  always_comb begin
    s           = S_W'(tt_r) * S_W'(k_r);
    res_nxt.hgt = hgt0_r;
    if (inside0_r) begin
      res_nxt.weight = WEIGHT_W'(W_ONE);
    end else if (beyond0_r) begin
      res_nxt.weight = '0;
    end else begin
      res_nxt.weight = s[2*WEIGHT_FRAC_BITS +: WEIGHT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      res_r <= res_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = res_r;

endmodule

`default_nettype wire

// File: rtl/frhb_blend.sv
// Two-stage blend: weight times height difference, then floor-shift and add to the base.
`default_nettype none

module frhb_blend (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire frhb_pkg::wgt_t                       in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [frhb_pkg::HEIGHT_W-1:0]      blended_height,
  output logic [frhb_pkg::WEIGHT_W-1:0]             region_weight
);
  import frhb_pkg::*;

  localparam int NSTG   = 2;
  localparam int PROD_W = DELTA_W + WEIGHT_W + 1;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;

  logic signed [PROD_W-1:0]   prod_r;
  logic signed [HEIGHT_W-1:0] base0_r;
  logic [WEIGHT_W-1:0]        w0_r;
  logic signed [HEIGHT_W-1:0] blend_r;
  logic [WEIGHT_W-1:0]        w1_r;

  assign rdy[NSTG] = out_ready;
  for (genvar g = 0; g < NSTG; g++) begin : g_rdy
    assign rdy[g] = ~v_r[g] | rdy[g+1];
  end

  assign v_nxt = (rdy[NSTG-1:0] & {v_r[NSTG-2:0], in_valid}) | (~rdy[NSTG-1:0] & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod_r  <= PROD_W'(in_data.hgt.delta) * $signed({1'b0, in_data.weight});
      base0_r <= in_data.hgt.base;
      w0_r    <= in_data.weight;
    end
  end

  // arithmetic shift floors toward negative infinity; the sum wraps to the field width
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      blend_r <= base0_r + prod_r[WEIGHT_FRAC_BITS +: HEIGHT_W];
      w1_r    <= w0_r;
    end
  end

  assign in_ready       = rdy[0];
  assign out_valid      = v_r[NSTG-1];
  assign blended_height = blend_r;
  assign region_weight  = w1_r;

endmodule

`default_nettype wire

// File: rtl/feathered_region_height_blend_top.sv
// Pipeline: 16 register stages from sample to result (distance 4, divider 8,
//   smoothstep 2, blend 2); the 16-bit restoring divider resolves 2 bits per stage.
// Throughput: one sample per cycle while the result side accepts; every stage holds its
//   own valid bit, so a stalled result register still lets earlier empty stages fill.
// Reset: synchronous, active low; clears all valid bits and the five configuration
//   registers to zero. Data registers are not reset.
`default_nettype none

module feathered_region_height_blend_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [frhb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [frhb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  frhb_in_if.sink                                 in_stream,
  frhb_out_if.source                              out_stream
);
  import frhb_pkg::*;

  cfg_t cfg_r;

  logic      dist_valid;
  logic      dist_ready;
  dist_res_t dist_data;
  logic      div_valid;
  logic      div_ready;
  ratio_t    div_data;
  logic      wgt_valid;
  logic      wgt_ready;
  wgt_t      wgt_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER_LON: cfg_r.center_lon <= cfg_wdata[LON_W-1:0];
        CFG_HALF_LON:   cfg_r.half_lon   <= cfg_wdata[SPAN_W-1:0];
        CFG_SOUTH_LAT:  cfg_r.south      <= cfg_wdata[LAT_W-1:0];
        CFG_NORTH_LAT:  cfg_r.north      <= cfg_wdata[LAT_W-1:0];
        CFG_FEATHER:    cfg_r.feather    <= cfg_wdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  frhb_dist u_dist (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_stream.valid),
    .in_ready        (in_stream.ready),
    .sample_lon      (in_stream.sample_lon),
    .sample_lat      (in_stream.sample_lat),
    .base_height     (in_stream.base_height),
    .filtered_height (in_stream.filtered_height),
    .out_valid       (dist_valid),
    .out_ready       (dist_ready),
    .out_data        (dist_data)
  );

  frhb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .feather   (cfg_r.feather),
    .in_valid  (dist_valid),
    .in_ready  (dist_ready),
    .in_data   (dist_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  frhb_weight u_weight (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .out_data  (wgt_data)
  );

  frhb_blend u_blend (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (wgt_valid),
    .in_ready       (wgt_ready),
    .in_data        (wgt_data),
    .out_valid      (out_stream.valid),
    .out_ready      (out_stream.ready),
    .blended_height (out_stream.blended_height),
    .region_weight  (out_stream.region_weight)
  );

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid |-> (out_stream.region_weight <= WEIGHT_W'(W_ONE)))
    else $error("region weight above one");

  // an empty result register must open the whole ready chain back to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stream.valid |-> in_stream.ready)
    else $error("input stalled while result register is empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_stream.valid)
    else $error("result valid right after reset");

  a_feather_zero_hard: assert property (@(posedge clk) disable iff (!rst_n)
    (div_valid && cfg_r.feather == '0) |-> (div_data.in_rect || div_data.beyond))
    else $error("feather band entered with zero feather width");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the feathered region height blend block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import frhb_pkg::*;

  localparam longint DEG         = longint'(1) << ANGLE_FRAC_BITS;
  localparam longint LON_LO      = -(longint'(1) << (LON_W - 1));
  localparam longint LON_HI      = (longint'(1) << (LON_W - 1)) - 1;
  localparam longint LAT_LO      = -(longint'(1) << (LAT_W - 1));
  localparam longint LAT_HI      = (longint'(1) << (LAT_W - 1)) - 1;
  localparam longint SPAN_HI     = (longint'(1) << SPAN_W) - 1;
  localparam longint H_LO        = -(longint'(1) << (HEIGHT_W - 1));
  localparam longint H_HI        = (longint'(1) << (HEIGHT_W - 1)) - 1;
  localparam int     PHASES      = 7;
  localparam int     PER_PHASE   = 236;
  localparam int     MAX_WAIT    = 6;
  localparam int     TAIL_CYCLES = 24;
  localparam int     STALL_LIMIT = 2000;
  localparam int     REPORT_MAX  = 10;

  typedef struct packed {
    logic signed [LON_W-1:0]    lon;
    logic signed [LAT_W-1:0]    lat;
    logic signed [HEIGHT_W-1:0] base;
    logic signed [HEIGHT_W-1:0] filt;
  } sample_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic [WEIGHT_W-1:0]        weight;
  } blend_t;

  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] value;
    sample_t               smp;
    bit                    typed;
    blend_t                want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frhb_in_if  in_stream();
  frhb_out_if out_stream();

  feathered_region_height_blend_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_stream),
    .out_stream (out_stream)
  );

  cfg_t      region;
  blend_t    pending_blends[$];
  stim_row_t stim_table[$];
  int        faults;
  bit        steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint blend_weight(input sample_t s);
    longint off, mag, dlon, dlat, edge_dist, feather, t, prod3;
    feather = longint'(region.feather);
    off = longint'($signed(s.lon)) - longint'($signed(region.center_lon));
    off = (off + HALF_TURN) % FULL_TURN;
    if (off < 0) off += FULL_TURN;
    off -= HALF_TURN;
    mag = (off < 0) ? -off : off;
    dlon = mag - longint'(region.half_lon);
    if (dlon < 0) dlon = 0;
    dlat = 0;
    if (longint'($signed(region.south)) - longint'($signed(s.lat)) > dlat)
      dlat = longint'($signed(region.south)) - longint'($signed(s.lat));
    if (longint'($signed(s.lat)) - longint'($signed(region.north)) > dlat)
      dlat = longint'($signed(s.lat)) - longint'($signed(region.north));
    edge_dist = (dlon > dlat) ? dlon : dlat;
    if (edge_dist <= 0) return W_ONE;
    if (edge_dist >= feather) return 0;
    t = ((feather - edge_dist) << WEIGHT_FRAC_BITS) / feather;
    prod3 = t * t * (3 * W_ONE - 2 * t);
    return prod3 >> (2 * WEIGHT_FRAC_BITS);
  endfunction

  function automatic blend_t predict_blend(input sample_t s);
    blend_t r;
    longint w, prod;
    w = blend_weight(s);
    prod = (longint'($signed(s.filt)) - longint'($signed(s.base))) * w;
    // arithmetic shift floors toward negative infinity
    r.height = HEIGHT_W'(longint'($signed(s.base)) + (prod >>> WEIGHT_FRAC_BITS));
    r.weight = WEIGHT_W'(w);
    return r;
  endfunction

  function automatic void add_reg(input cfg_idx_t index, input longint value);
    stim_row_t r;
    r.kind  = ROW_REG;
    r.index = index;
    r.value = CFG_DATA_W'(value);
    r.smp   = '0;
    r.typed = 1'b0;
    r.want  = '0;
    stim_table = {stim_table, r};
  endfunction

  function automatic void add_sample(input longint lon, input longint lat, input longint base,
                                     input longint filt, input bit typed,
                                     input longint want_h, input longint want_w);
    stim_row_t r;
    r.kind        = ROW_SAMPLE;
    r.index       = CFG_CENTER_LON;
    r.value       = '0;
    r.smp.lon     = LON_W'(lon);
    r.smp.lat     = LAT_W'(lat);
    r.smp.base    = HEIGHT_W'(base);
    r.smp.filt    = HEIGHT_W'(filt);
    r.typed       = typed;
    r.want.height = HEIGHT_W'(want_h);
    r.want.weight = WEIGHT_W'(want_w);
    stim_table = {stim_table, r};
  endfunction

  function automatic void build_directed();
    // reset state: the rectangle is a single point at the origin with a hard edge
    add_sample(0, 0, H_HI, H_LO, 1, H_LO, W_ONE);
    add_sample(0, 0, H_LO, H_HI, 1, H_HI, W_ONE);
    add_sample(1, 0, 123, 999, 1, 123, 0);
    add_sample(0, -1, -5, 77, 1, -5, 0);
    add_sample(LON_HI, LAT_LO, -1, 0, 1, -1, 0);
    add_sample(LON_LO, LAT_HI, 0, -1, 1, 0, 0);
    add_sample(180 * DEG, 0, 42, -42, 1, 42, 0);
    add_sample(-180 * DEG, 0, -42, 42, 1, -42, 0);
    // rectangle ending at the date line, with a soft edge reaching across it
    add_reg(CFG_CENTER_LON, 170 * DEG);
    add_reg(CFG_HALF_LON, 10 * DEG);
    add_reg(CFG_SOUTH_LAT, -10 * DEG);
    add_reg(CFG_NORTH_LAT, 10 * DEG);
    add_reg(CFG_FEATHER, 20 * DEG);
    add_sample(175 * DEG, 0, 1000, 2000, 1, 2000, W_ONE);
    add_sample(-175 * DEG, 0, 1000, -3000, 0, 0, 0);
    add_sample(-160 * DEG, 0, 5, 9, 1, 5, 0);
    add_sample(180 * DEG + 1, 0, -7, 100000, 0, 0, 0);
    add_sample(170 * DEG, 30 * DEG - 1, H_HI, H_LO, 0, 0, 0);
    add_sample(170 * DEG, -25 * DEG, H_LO, H_HI, 0, 0, 0);
    add_sample(170 * DEG, 10 * DEG, 3, 4, 1, 4, W_ONE);
    // hard edge
    add_reg(CFG_FEATHER, 0);
    add_sample(180 * DEG, 10 * DEG, 3, 4, 1, 4, W_ONE);
    add_sample(180 * DEG + 1, 0, 3, 4, 1, 3, 0);
    // north below south, narrowest feather
    add_reg(CFG_SOUTH_LAT, 10 * DEG);
    add_reg(CFG_NORTH_LAT, -10 * DEG);
    add_reg(CFG_FEATHER, 1);
    add_sample(170 * DEG, 0, 11, 22, 1, 11, 0);
    // widest span and feather, with the unused top data bit set
    add_reg(CFG_HALF_LON, (longint'(1) << CFG_DATA_W) - 1);
    add_reg(CFG_FEATHER, (longint'(1) << CFG_DATA_W) - 1);
    add_sample(170 * DEG, 0, -1000, 1000, 0, 0, 0);
    add_sample(LON_LO, LAT_HI, H_HI, H_LO, 0, 0, 0);
    add_reg(CFG_CENTER_LON, LON_LO);
    add_sample(0, 0, 77, -77, 0, 0, 0);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_loose_top(input longint x);
    return {1'($urandom), x[SPAN_W-1:0]};
  endfunction

  function automatic longint pick_height();
    case ($urandom_range(0, 3))
      0: return H_LO;
      1: return H_HI;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    longint reach, lon, lat, lo, hi, edge_lat;
    int kind;
    reach = longint'(region.feather) + longint'(region.feather >> 2) + 2;
    lo = longint'($signed(region.south));
    hi = longint'($signed(region.north));
    if (lo > hi) begin
      lo = longint'($signed(region.north));
      hi = longint'($signed(region.south));
    end
    kind = $urandom_range(0, 9);
    // longitude: just past an edge of the span or somewhere within it
    if (kind <= 4 || kind >= 8)
      lon = longint'(region.half_lon) + longint'($urandom_range(0, 32'(reach)));
    else
      lon = longint'($urandom_range(0, 32'(region.half_lon)));
    if ($urandom_range(0, 1)) lon = -lon;
    lon += longint'($signed(region.center_lon));
    if (kind == 9) lon += (longint'($urandom_range(0, 2)) - 1) * FULL_TURN;
    // latitude: inside the band or near one of its edges
    if (kind >= 1 && kind <= 4) begin
      lat = lo + longint'($urandom_range(0, 32'(hi - lo)));
    end else begin
      edge_lat = $urandom_range(0, 1) ? longint'($signed(region.south))
                                      : longint'($signed(region.north));
      lat = edge_lat + longint'($urandom_range(0, 32'(2 * reach))) - reach;
    end
    if (kind == 0) begin
      lon = longint'($urandom);
      lat = longint'($urandom);
    end
    s.lon  = lon[LON_W-1:0];
    s.lat  = lat[LAT_W-1:0];
    s.base = $urandom;
    if ($urandom_range(0, 3) == 0)
      s.filt = s.base + HEIGHT_W'(longint'($urandom_range(0, 64)) - 32);
    else
      s.filt = $urandom;
    if ($urandom_range(0, 7) == 0) s.base = HEIGHT_W'(pick_height());
    if ($urandom_range(0, 7) == 0) s.filt = HEIGHT_W'(pick_height());
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_CENTER_LON: region.center_lon = value;
      CFG_HALF_LON:   region.half_lon   = value[SPAN_W-1:0];
      CFG_SOUTH_LAT:  region.south      = value[LAT_W-1:0];
      CFG_NORTH_LAT:  region.north      = value[LAT_W-1:0];
      CFG_FEATHER:    region.feather    = value[SPAN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drop valid and hold until every result has come back
  task automatic settle();
    in_stream.valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
  endtask

  task automatic program_region(input int phase);
    longint center, half, south, north, feather, tmp;
    case (phase)
      0: begin
        center = LON_LO; half = 0; south = LAT_LO; north = LAT_LO; feather = 0;
      end
      1: begin
        center = LON_HI; half = SPAN_HI; south = LAT_LO; north = LAT_HI; feather = SPAN_HI;
      end
      default: begin
        if ($urandom_range(0, 4) == 0)
          center = $urandom_range(0, 1) ? LON_LO : LON_HI;
        else
          center = longint'($urandom_range(0, 32'(2 * HALF_TURN))) - HALF_TURN;
        if ($urandom_range(0, 4) == 0)
          half = $urandom_range(0, 1) ? 0 : SPAN_HI;
        else
          half = longint'($urandom_range(0, 32'(90 * DEG)));
        south = longint'($urandom_range(0, 32'(180 * DEG))) - 90 * DEG;
        north = longint'($urandom_range(0, 32'(180 * DEG))) - 90 * DEG;
        if (south > north && $urandom_range(0, 5) != 0) begin
          tmp = south; south = north; north = tmp;
        end
        if ($urandom_range(0, 4) == 0) south = LAT_LO;
        if ($urandom_range(0, 4) == 0) north = LAT_HI;
        case ($urandom_range(0, 9))
          0: feather = 0;
          1: feather = SPAN_HI;
          2: feather = longint'($urandom_range(1, 16));
          default: feather = longint'($urandom_range(1, 32'(30 * DEG)));
        endcase
      end
    endcase
    write_reg(CFG_CENTER_LON, CFG_DATA_W'(center));
    write_reg(CFG_HALF_LON, with_loose_top(half));
    write_reg(CFG_SOUTH_LAT, with_loose_top(south));
    write_reg(CFG_NORTH_LAT, with_loose_top(north));
    write_reg(CFG_FEATHER, with_loose_top(feather));
    // unused indexes must leave every register alone
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'($urandom_range(CFG_FEATHER + 1, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
  endtask

  task automatic send_sample(input sample_t s, input blend_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_stream.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_stream.valid           <= 1'b1;
    in_stream.sample_lon      <= s.lon;
    in_stream.sample_lat      <= s.lat;
    in_stream.base_height     <= s.base;
    in_stream.filtered_height <= s.filt;
    do @(posedge clk); while (!in_stream.ready);
    pending_blends = {pending_blends, want};
  endtask

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= REPORT_MAX) $display("%s", msg);
  endtask

  // result side: check each transfer, then draw a stall before the next one
  initial begin
    int     stall_left;
    blend_t got, want;
    stall_left = 0;
    out_stream.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_stream.valid && out_stream.ready) begin
        got.height = out_stream.blended_height;
        got.weight = out_stream.region_weight;
        if (pending_blends.size() == 0) begin
          note_fault($sformatf("unexpected result: height %0d weight %0d",
                               got.height, got.weight));
        end else begin
          want = pending_blends.pop_front();
          if (got.height !== want.height || got.weight !== want.weight)
            note_fault($sformatf("mismatch: height exp %0d got %0d, weight exp %0d got %0d",
                                 want.height, got.height, want.weight, got.weight));
        end
        stall_left = steady ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stream.ready <= rst_n && (stall_left == 0);
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_stream.valid && in_stream.ready) ||
          (out_stream.valid && out_stream.ready))
        idle = 0;
      else
        idle++;
      if (idle >= STALL_LIMIT) begin
        $display("FAIL feathered_region_height_blend_top");
        $finish;
      end
    end
  end

  initial begin
    sample_t s;
    faults = 0;
    steady = 1'b0;
    region = '0;
    rst_n                     <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_index                 <= '0;
    cfg_wdata                 <= '0;
    in_stream.valid           <= 1'b0;
    in_stream.sample_lon      <= '0;
    in_stream.sample_lat      <= '0;
    in_stream.base_height     <= '0;
    in_stream.filtered_height <= '0;
    build_directed();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_REG) begin
        settle();
        write_reg(stim_table[i].index, stim_table[i].value);
      end else begin
        send_sample(stim_table[i].smp,
                    stim_table[i].typed ? stim_table[i].want : predict_blend(stim_table[i].smp));
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      program_region(phase);
      for (int i = 0; i < PER_PHASE; i++) begin
        if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        s = random_sample();
        send_sample(s, predict_blend(s));
      end
    end
    steady = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0 && pending_blends.size() == 0)
      $display("PASS feathered_region_height_blend_top");
    else
      $display("FAIL feathered_region_height_blend_top");
    $finish;
  end

endmodule
